@@ design/bmp_4bpp_palette_decoder_macros.svh @@
// Assertion macros for the palette decoder.
`ifndef BMP_4BPP_PALETTE_DECODER_MACROS_SVH
`define BMP_4BPP_PALETTE_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMP_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define BMP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BMP_ASSERT_IMPL(label, clk, rst, a, c)
`define BMP_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ design/bmp_pkg.sv @@
`default_nettype none
package bmp_pkg;
  localparam logic [15:0] BMP_MAGIC = 16'd19778;
  localparam logic [6:0] HEADER_BYTES = 7'd54;
  localparam logic [3:0] ST_PIXEL = 4'd0;
  localparam logic [3:0] ST_MAGIC = 4'd1;
  localparam logic [3:0] ST_PLANES = 4'd2;
  localparam logic [3:0] ST_DEPTH = 4'd3;
  localparam logic [3:0] ST_COMPRESSION = 4'd4;
  localparam logic [3:0] ST_HEADER_SIZE = 4'd5;
  localparam logic [3:0] ST_DIMENSIONS = 4'd6;
  localparam logic [3:0] ST_PALETTE_COUNT = 4'd7;
  localparam logic [3:0] ST_INDEX = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] pixel_row;
    logic [9:0] pixel_column;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

@@ design/bmp_ram.sv @@
`default_nettype none
module bmp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/bmp_4bpp_palette_decoder.sv @@
// Streaming decoder for 4-bit palettised BMP files, one file byte per input
// item. Header and palette bytes are taken one per cycle unless the output
// stalls, and give no result, except a header error. A pixel byte gives up
// to two pixels through the single output port; the second nibble waits in
// a pending register and no new byte is taken until it has gone. Errors end
// the file, and the block then drops bytes until start_of_file. pixel_row and
// pixel_column wrap at 1024.
`default_nettype none
`include "bmp_4bpp_palette_decoder_macros.svh"
module bmp_4bpp_palette_decoder import bmp_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);
  localparam int PE = 16;
  localparam int DW = 13;

  typedef enum logic [1:0] {PH_HEADER, PH_PALETTE, PH_PIXELS, PH_IDLE} phase_t;

  phase_t      phase;
  logic [6:0]  pos;
  logic [31:0] acc;
  logic [DW-1:0] width;
  logic [DW-1:0] height;
  logic [4:0]  pcount;
  logic [DW-1:0] row;
  logic [DW-1:0] col;
  logic [1:0]  pad;

  // second nibble waiting for its turn
  logic        pend;
  logic [3:0]  pend_idx;

  // stage between the RAM read and the output register
  logic        s_valid;
  logic [3:0]  s_status;
  logic [9:0]  s_row, s_col;
  logic        s_last;
  logic [3:0]  s_idx;
  logic [23:0] rdata;

  logic        stall;
  assign stall = s_valid && out_valid && !out_ready;
  assign in_ready = !pend && !stall;

  logic        acc_in;
  assign acc_in = in_valid && in_ready;

  // Combinational parse of the current header byte: shifted accumulator and header check.
  logic [31:0] acc_n;
  logic [3:0]  herr;
  always_comb begin
    acc_n = {in_data.data_byte, acc[31:8]};
    herr = ST_PIXEL;
    case (pos)
      7'd1:  if (acc_n[31:16] != BMP_MAGIC) herr = ST_MAGIC;
      7'd17: if (acc_n != 32'd40) herr = ST_HEADER_SIZE;
      7'd21: if (acc_n < 32'd1 || acc_n > 32'(MAX_WIDTH)) herr = ST_DIMENSIONS;
      7'd25: if (acc_n < 32'd1 || acc_n > 32'(MAX_HEIGHT)) herr = ST_DIMENSIONS;
      7'd27: if (acc_n[31:16] != 16'd1) herr = ST_PLANES;
      7'd29: if (acc_n[31:16] != 16'd4) herr = ST_DEPTH;
      7'd33: if (acc_n != 32'd0) herr = ST_COMPRESSION;
      7'd49: if (acc_n > 32'd16) herr = ST_PALETTE_COUNT;
      default: herr = ST_PIXEL;
    endcase
  end

  logic        herr_go;
  assign herr_go = acc_in && !in_data.start_of_file && phase == PH_HEADER
                   && herr != ST_PIXEL;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  assign ram_we = acc_in && !in_data.start_of_file && phase == PH_PALETTE
                  && pos[1:0] == 2'b11;
  assign ram_waddr = pos[5:2];

  // pixel step inputs
  logic        pix_go;
  logic [3:0]  pix_idx;
  logic        first_pix;
  assign first_pix = acc_in && !in_data.start_of_file && phase == PH_PIXELS
                     && pad == 2'd0;
  assign pix_go = !stall && (pend || first_pix);
  assign pix_idx = pend ? pend_idx : in_data.data_byte[7:4];
  // While a pixel waits in the stage, its colour is read again every cycle.
  assign ram_raddr = pix_go ? pix_idx : s_idx;

  bmp_ram #(.WIDTH(24), .DEPTH(PE)) u_pal (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(acc_n[23:0]),
    .raddr(ram_raddr), .rdata(rdata)
  );

  logic [DW-1:0] pad_w;
  assign pad_w = DW'(0) - ((width + DW'(1)) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; pos <= '0; acc <= '0; width <= '0; height <= '0;
      pcount <= '0; row <= '0; col <= '0; pad <= '0; pend <= 1'b0;
      s_valid <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (!stall) begin
        s_valid <= pix_go || herr_go;
        if (s_valid) begin
          out_valid <= 1'b1;
          out_data.status <= s_status;
          out_data.red <= s_status == ST_PIXEL ? rdata[23:16] : 8'd0;
          out_data.green <= s_status == ST_PIXEL ? rdata[15:8] : 8'd0;
          out_data.blue <= s_status == ST_PIXEL ? rdata[7:0] : 8'd0;
          out_data.pixel_row <= s_row;
          out_data.pixel_column <= s_col;
          out_data.last <= s_last;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
      if (pix_go) begin
        s_row <= row[9:0];
        s_col <= col[9:0];
        s_idx <= pix_idx;
        if ({1'b0, pix_idx} >= pcount) begin
          s_status <= ST_INDEX; s_last <= 1'b1; phase <= PH_IDLE; pend <= 1'b0;
        end else if (row == '0 && col + DW'(1) >= width) begin
          s_status <= ST_PIXEL; s_last <= 1'b1; phase <= PH_IDLE; pend <= 1'b0;
        end else begin
          s_status <= ST_PIXEL; s_last <= 1'b0;
          if (col + DW'(1) >= width) begin
            row <= row - DW'(1); col <= '0; pad <= pad_w[1:0]; pend <= 1'b0;
          end else begin
            col <= col + DW'(1);
            pend <= !pend;
            if (!pend) pend_idx <= in_data.data_byte[3:0];
          end
        end
      end else if (acc_in) begin
        phase_t ph;
        ph = in_data.start_of_file ? PH_HEADER : phase;
        if (in_data.start_of_file) begin
          phase <= PH_HEADER; width <= '0; height <= '0;
          pcount <= '0; row <= '0; col <= '0; pad <= '0;
        end
        case (ph)
          PH_HEADER: begin
            if (herr_go) begin
              s_status <= herr; s_row <= '0; s_col <= '0;
              s_last <= 1'b1; phase <= PH_IDLE;
            end else if (in_data.start_of_file) begin
              acc <= {in_data.data_byte, 24'd0};
              pos <= 7'd1;
            end else begin
              acc <= acc_n;
              if (pos == 7'd21) width <= acc_n[DW-1:0];
              if (pos == 7'd25) height <= acc_n[DW-1:0];
              if (pos == 7'd49) pcount <= acc_n[4:0] == 5'd0 ? 5'd16 : acc_n[4:0];
              if (pos + 7'd1 >= HEADER_BYTES) begin
                phase <= PH_PALETTE; pos <= '0; acc <= '0;
              end else begin
                pos <= pos + 7'd1;
              end
            end
          end
          PH_PALETTE: begin
            acc <= acc_n;
            if ({1'b0, pos} + 8'd1 >= {1'b0, pcount, 2'b00}) begin
              phase <= PH_PIXELS; pos <= '0; acc <= '0;
              row <= height - DW'(1); col <= '0; pad <= '0;
            end else begin
              pos <= pos + 7'd1;
            end
          end
          PH_PIXELS: if (pad != 2'd0) pad <= pad - 2'd1;
          default: ;
        endcase
      end
    end
  end

  `BMP_ASSERT_IMPL(a_pend_no_ready, clk, rst, pend, !in_ready)
  `BMP_ASSERT_NEXT(a_err_idle, clk, rst,
    s_valid && !stall && s_last, phase == PH_IDLE || $past(acc_in))
  `BMP_ASSERT_IMPL(a_err_black, clk, rst,
    out_valid && out_data.status != ST_PIXEL,
    out_data.last && out_data.red == 8'd0)
endmodule
`default_nettype wire

@@ tb/tb_bmp_4bpp_palette_decoder.sv @@
`timescale 1ns / 100ps
`default_nettype none

module tb_bmp_4bpp_palette_decoder;
  import bmp_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int PAL_ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic [1:0] {PH_HEADER, PH_PALETTE, PH_PIXELS, PH_IDLE} phase_e;

  // Behavioural decoder with its own copy of the parse state.
  class pixel_scoreboard;
    phase_e      phase;
    int unsigned pos;
    logic [31:0] acc;
    int unsigned width, height, ncolours;
    logic [23:0] colours [PAL_ENTRIES];
    int unsigned row, col, pad_left;
    out_item_t   pending [$];
    int          mismatches;
    int          pixels_seen, errors_seen, images_done;

    function new();
      phase = PH_HEADER;
      pos = 0; acc = 0; width = 0; height = 0; ncolours = 0;
      row = 0; col = 0; pad_left = 0; mismatches = 0;
      pixels_seen = 0; errors_seen = 0; images_done = 0;
      foreach (colours[i]) colours[i] = '0;
    endfunction

    function void restart();
      phase = PH_HEADER;
      pos = 0; acc = 0; width = 0; height = 0; ncolours = 0;
      row = 0; col = 0; pad_left = 0;
    endfunction

    function void push_result(logic [3:0] st, logic [23:0] rgb, int unsigned r,
                              int unsigned c, logic lst);
      out_item_t o;
      o.status = st;
      o.red = rgb[23:16];
      o.green = rgb[15:8];
      o.blue = rgb[7:0];
      o.pixel_row = r[9:0];
      o.pixel_column = c[9:0];
      o.last = lst;
      pending.push_back(o);
    endfunction

    function logic [3:0] header_fault();
      logic [15:0] upper;
      upper = acc[31:16];
      case (pos)
        1: return (upper != BMP_MAGIC) ? ST_MAGIC : ST_PIXEL;
        17: return (acc != 32'd40) ? ST_HEADER_SIZE : ST_PIXEL;
        21: begin
          if (acc < 1 || acc > MAX_W) return ST_DIMENSIONS;
          width = acc;
          return ST_PIXEL;
        end
        25: begin
          if (acc < 1 || acc > MAX_H) return ST_DIMENSIONS;
          height = acc;
          return ST_PIXEL;
        end
        27: return (upper != 16'd1) ? ST_PLANES : ST_PIXEL;
        29: return (upper != 16'd4) ? ST_DEPTH : ST_PIXEL;
        33: return (acc != 0) ? ST_COMPRESSION : ST_PIXEL;
        49: begin
          if (acc > PAL_ENTRIES) return ST_PALETTE_COUNT;
          ncolours = (acc == 0) ? PAL_ENTRIES : acc;
          return ST_PIXEL;
        end
        default: return ST_PIXEL;
      endcase
    endfunction

    function void note_byte(in_item_t it);
      logic [3:0] fault;
      logic [3:0] idx;
      if (it.start_of_file) restart();
      case (phase)
        PH_HEADER: begin
          acc = {it.data_byte, acc[31:8]};
          fault = header_fault();
          if (fault != ST_PIXEL) begin
            push_result(fault, '0, 0, 0, 1'b1);
            errors_seen++;
            phase = PH_IDLE;
            return;
          end
          pos++;
          if (pos >= HEADER_BYTES) begin
            phase = PH_PALETTE; pos = 0; acc = 0;
          end
        end
        PH_PALETTE: begin
          acc = {it.data_byte, acc[31:8]};
          if (pos[1:0] == 2'd3) colours[pos[5:2]] = acc[23:0];
          pos++;
          if (pos >= 4 * ncolours) begin
            phase = PH_PIXELS; pos = 0; acc = 0;
            row = height - 1; col = 0; pad_left = 0;
          end
        end
        PH_PIXELS: begin
          if (pad_left != 0) begin
            pad_left--;
            return;
          end
          for (int i = 0; i < 2; i++) begin
            idx = (i == 0) ? it.data_byte[7:4] : it.data_byte[3:0];
            if (idx >= ncolours) begin
              push_result(ST_INDEX, '0, row, col, 1'b1);
              errors_seen++;
              phase = PH_IDLE;
              return;
            end
            if (row == 0 && col + 1 >= width) begin
              push_result(ST_PIXEL, colours[idx], row, col, 1'b1);
              pixels_seen++;
              images_done++;
              phase = PH_IDLE;
              return;
            end
            push_result(ST_PIXEL, colours[idx], row, col, 1'b0);
            pixels_seen++;
            col++;
            if (col >= width) begin
              row--;
              col = 0;
              pad_left = (4 - ((width + 1) / 2) % 4) % 4;
              break;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pixel_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit hold_receiver = 1'b0;
  int idle_run = 0;

  always #1 clk = ~clk;

  bmp_4bpp_palette_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Receiver: random back-pressure, none in the quiet phase; held low on hold_receiver.
  always @(negedge clk) begin
    if (rst || hold_receiver) out_ready <= 1'b0;
    else if (quiet_phase) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driven with blocking assignments at the falling edge, so a new item may
  // follow in the same step that the previous one is withdrawn.
  task automatic send_byte(logic [7:0] b, logic sof);
    while (!quiet_phase && $urandom_range(99) < 36) @(negedge clk);
    in_valid = 1'b1;
    in_data = '{data_byte: b, start_of_file: sof};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte('{data_byte: b, start_of_file: sof});
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_le(int unsigned v, int nbytes, logic sof);
    for (int i = 0; i < nbytes; i++) send_byte(v[8*i +: 8], sof && i == 0);
  endtask

  // One file; fault corrupts a header field or none, bad_index a pixel index.
  task automatic send_file(int unsigned w, int unsigned h, int unsigned ncol,
                           logic [3:0] fault, bit bad_index);
    int unsigned stride, used, n;
    logic [7:0] b;
    logic [3:0] hi, lo;
    n = (ncol == 0) ? PAL_ENTRIES : ncol;
    send_le((fault == ST_MAGIC) ? $urandom_range(65535) & 16'hFFBD : BMP_MAGIC,
            2, 1'b1);
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_le((fault == ST_HEADER_SIZE) ? 41 : 40, 4, 1'b0);
    send_le((fault == ST_DIMENSIONS) ? ($urandom_range(1) ? 0 : MAX_W + 1) : w,
            4, 1'b0);
    send_le((fault == ST_DIMENSIONS && $urandom_range(1)) ? -h : h, 4, 1'b0);
    send_le((fault == ST_PLANES) ? $urandom_range(2, 65535) : 1, 2, 1'b0);
    send_le((fault == ST_DEPTH) ? 8 : 4, 2, 1'b0);
    send_le((fault == ST_COMPRESSION) ? $urandom_range(1, 3) : 0, 4, 1'b0);
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_le((fault == ST_PALETTE_COUNT) ? $urandom_range(17, 255) : ncol, 4, 1'b0);
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)), 1'b0);
    if (fault != ST_PIXEL) return;
    for (int i = 0; i < 4 * n; i++) send_byte(8'($urandom_range(255)), 1'b0);
    stride = ((w + 7) / 8) * 4;
    used = (w + 1) / 2;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < stride; c++) begin
        hi = 4'($urandom_range(n - 1));
        lo = 4'($urandom_range(n - 1));
        if (bad_index && r == h - 1 && c == used - 1) lo = 4'hF;
        b = (c < used) ? {hi, lo} : 8'($urandom_range(255));
        send_byte(b, 1'b0);
      end
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [3:0] fault;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: each header fault, palette count extremes, odd and aligned widths.
    send_file(3, 2, 16, ST_MAGIC, 0);
    send_file(3, 2, 16, ST_HEADER_SIZE, 0);
    send_file(3, 2, 16, ST_DIMENSIONS, 0);
    send_file(3, 2, 16, ST_PLANES, 0);
    send_file(3, 2, 16, ST_DEPTH, 0);
    send_file(3, 2, 16, ST_COMPRESSION, 0);
    send_file(3, 2, 16, ST_PALETTE_COUNT, 0);
    send_file(1, 1, 0, ST_PIXEL, 0);
    send_file(8, 2, 1, ST_PIXEL, 0);
    send_file(5, 2, 4, ST_PIXEL, 1);
    send_file(255, 1, 16, ST_PIXEL, 0);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), 1'b0);
    drain();

    // Long receiver hold while the sender keeps offering pixel bytes.
    fork
      begin
        hold_receiver = 1'b1;
        repeat (300) @(negedge clk);
        hold_receiver = 1'b0;
      end
      send_file(30, 6, 9, ST_PIXEL, 0);
    join
    drain();

    quiet_phase = 1'b1;
    send_file(17, 3, 7, ST_PIXEL, 0);
    quiet_phase = 1'b0;
    drain();

    for (int k = 0; k < 2; k++) begin
      fault = ($urandom_range(5) == 0) ? 4'($urandom_range(ST_MAGIC, ST_PALETTE_COUNT))
                                       : ST_PIXEL;
      send_file($urandom_range(1, 24), $urandom_range(1, 4), $urandom_range(16),
                fault, $urandom_range(9) == 0);
      if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)), 1'b0);
    end
    drain();

    $display("Decoded %0d pixels over %0d complete images; %0d faulty files flagged.",
             sb.pixels_seen, sb.images_done, sb.errors_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, results outstanding: %0d",
               sb.mismatches, sb.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ bmp_4bpp_palette_decoder.f @@
+incdir+design
design/bmp_pkg.sv
design/bmp_ram.sv
design/bmp_4bpp_palette_decoder.sv
tb/tb_bmp_4bpp_palette_decoder.sv
